// ===== sv/ordered_route_table_lookup_top_macros.svh =====
// ----------------------------------------------------------------------------
// Route table assertion macros
// Shared concurrent assertion forms clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ROUTE_TABLE_LOOKUP_TOP_MACROS_SVH
`define ORDERED_ROUTE_TABLE_LOOKUP_TOP_MACROS_SVH

// property that must hold at every edge outside reset
`define ORTL_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define ORTL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ortl_pkg.sv =====
// ----------------------------------------------------------------------------
// Route table package
// Types and fixed field widths shared by the table cells and the top level.
// ----------------------------------------------------------------------------
package ortl_pkg;

    localparam int ADDR_W   = 32;
    localparam int METRIC_W = 16;
    localparam int IFACE_W  = 4;
    localparam int TDATA_W  = 120;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DEL    = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_DEFRT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_EXISTS   = 2'd1,
        STS_NOTFOUND = 2'd2,
        STS_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEL,
        ST_APPLY,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_PREV,
        CELL_NEXT
    } cell_op_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   mask;
        logic [ADDR_W-1:0]   gateway;
        logic [METRIC_W-1:0] metric;
    } route_key_t;

    typedef struct packed {
        logic hit;
        logic eq;
        logic ins;
    } cell_flags_t;

endpackage

// ===== sv/ordered_route_table_lookup_top.sv =====
// Each command passes through the compare, first-match select and apply states over the
// row of route cells, then waits in the response state until the output register is free;
// a resolving default route repeats compare, select and apply as an add of 0/0. A new
// command is accepted only in idle, once the previous result has been registered.
// Reset clears every cell valid bit and the controller; route payload is not
// reset and is only ever read from valid cells.
// ----------------------------------------------------------------------------
// Ordered route table top level
// Sorted IPv4 route table built as a row of shifting cells with add, delete,
// longest-mask-first lookup and default route commands.
// ----------------------------------------------------------------------------
module ordered_route_table_lookup_top
    import ortl_pkg::*;
#(
    parameter int ROUTE_ENTRIES = 16,
    parameter int IFACE_BITS    = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // address, netmask, gateway, metric, iface, zero pad
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic [1:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // hit_dest, hit_mask, hit_gateway, hit_metric, hit_iface, zero pad
    output logic [TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]         m_axis_tuser
);

    `include "ordered_route_table_lookup_top_macros.svh"

    localparam logic [ROUTE_ENTRIES-1:0] VEC_ONE = ROUTE_ENTRIES'(1);

    state_t                  state_reg, state_next;
    cmd_t                    op_reg;
    route_key_t              key_reg;
    logic [IFACE_BITS-1:0]   key_iface_reg;
    logic [ROUTE_ENTRIES-1:0] sel_reg, sel_next;
    logic                    any_reg, any_next;
    logic                    dup_reg;
    logic                    full_reg;
    status_t                 res_status_reg;
    route_key_t              res_key_reg;
    logic [IFACE_W-1:0]      res_iface_reg;
    logic                    m_tvalid_reg;
    logic [TDATA_W-1:0]      m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    logic [ROUTE_ENTRIES-1:0] valid_v, hit_v, eq_v, ins_v;
    route_key_t               entry_v [ROUTE_ENTRIES];
    logic [IFACE_BITS-1:0]    iface_v [ROUTE_ENTRIES];
    cell_flags_t              flags_v [ROUTE_ENTRIES];
    cell_op_t                 cell_op [ROUTE_ENTRIES];

    logic                     in_xfer;
    logic                     out_free;
    logic                     add_ok;
    logic                     defrt_ok;
    route_key_t               found_key;
    logic [IFACE_BITS-1:0]    found_iface;
    logic [ROUTE_ENTRIES-1:0] first_v;
    logic [IFACE_W+IFACE_BITS-1:0] in_iface_ext;
    logic [IFACE_W+IFACE_BITS-1:0] out_iface_ext;
    cmd_t                     in_cmd;

    // ------------------------------------------------------------------ cells
    genvar gi;
    generate
        for (gi = 0; gi < ROUTE_ENTRIES; gi++)
        begin : g_cell
            logic                  prev_valid, next_valid;
            route_key_t            prev_entry, next_entry;
            logic [IFACE_BITS-1:0] prev_iface, next_iface;

            if (gi == 0)
            begin : g_head
                assign prev_valid = 1'b0;
                assign prev_entry = '0;
                assign prev_iface = '0;
            end
            else
            begin : g_mid
                assign prev_valid = valid_v[gi-1];
                assign prev_entry = entry_v[gi-1];
                assign prev_iface = iface_v[gi-1];
            end

            if (gi == ROUTE_ENTRIES - 1)
            begin : g_tail
                assign next_valid = 1'b0;
                assign next_entry = '0;
                assign next_iface = '0;
            end
            else
            begin : g_body
                assign next_valid = valid_v[gi+1];
                assign next_entry = entry_v[gi+1];
                assign next_iface = iface_v[gi+1];
            end

            ortl_cell #(
                .IFACE_BITS (IFACE_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (cell_op[gi]),
                .key        (key_reg),
                .key_iface  (key_iface_reg),
                .prev_valid (prev_valid),
                .prev_entry (prev_entry),
                .prev_iface (prev_iface),
                .next_valid (next_valid),
                .next_entry (next_entry),
                .next_iface (next_iface),
                .valid      (valid_v[gi]),
                .entry      (entry_v[gi]),
                .iface      (iface_v[gi]),
                .flags      (flags_v[gi])
            );

            assign hit_v[gi] = flags_v[gi].hit;
            assign eq_v[gi]  = flags_v[gi].eq;
            assign ins_v[gi] = flags_v[gi].ins;
        end
    endgenerate

    // ------------------------------------------------------------ datapath
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_tvalid_reg || m_axis_tready;
    assign in_cmd   = cmd_t'(s_axis_tuser);

    assign in_iface_ext = {{IFACE_BITS{1'b0}}, s_axis_tdata[115:112]};

    // insert positions for add, first-match select for lookup and default route, first exact match onward for delete
    always_comb
    begin
        sel_next = '0;
        any_next = 1'b0;
        first_v  = '0;
        case (op_reg)
            CMD_ADD:
            begin
                sel_next = ins_v;
            end
            CMD_DEL:
            begin
                first_v  = eq_v & (~eq_v + VEC_ONE);
                any_next = |eq_v;
                sel_next = any_next ? ~(first_v - VEC_ONE) : '0;
            end
            default:
            begin
                first_v  = hit_v & (~hit_v + VEC_ONE);
                any_next = |hit_v;
                sel_next = first_v;
            end
        endcase
    end

    // and-or read of the selected cells, one-hot for lookup and default route
    always_comb
    begin
        found_key   = '0;
        found_iface = '0;
        for (int i = 0; i < ROUTE_ENTRIES; i++)
        begin
            if (sel_reg[i])
            begin
                found_key   = found_key | entry_v[i];
                found_iface = found_iface | iface_v[i];
            end
        end
    end

    assign out_iface_ext = {{IFACE_W{1'b0}}, found_iface};
    assign add_ok   = !dup_reg && !full_reg;
    assign defrt_ok = any_reg && (found_key.dest != '0) && (found_key.gateway == '0);

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if ((op_reg == CMD_DEFRT) && defrt_ok)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------ outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        for (int i = 0; i < ROUTE_ENTRIES; i++)
        begin
            cell_op[i] = CELL_HOLD;
            if (state_reg == ST_APPLY)
            begin
                if ((op_reg == CMD_ADD) && add_ok)
                begin
                    if ((i > 0) && sel_reg[(i > 0) ? i - 1 : 0])
                    begin
                        cell_op[i] = CELL_PREV;
                    end
                    else if (sel_reg[i])
                    begin
                        cell_op[i] = CELL_LOAD;
                    end
                end
                else if ((op_reg == CMD_DEL) && sel_reg[i])
                begin
                    cell_op[i] = CELL_NEXT;
                end
            end
        end
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= CMD_ADD;
            sel_reg      <= '0;
            any_reg      <= 1'b0;
            dup_reg      <= 1'b0;
            full_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                op_reg <= in_cmd;
            end
            else if ((state_reg == ST_APPLY) && (op_reg == CMD_DEFRT) && defrt_ok)
            begin
                op_reg <= CMD_ADD;
            end
            if (state_reg == ST_SEL)
            begin
                sel_reg  <= sel_next;
                any_reg  <= any_next;
                dup_reg  <= |eq_v;
                full_reg <= valid_v[ROUTE_ENTRIES-1];
            end
            if ((state_reg == ST_RESP) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            key_reg.mask    <= s_axis_tdata[63:32];
            key_reg.gateway <= s_axis_tdata[95:64];
            key_reg.metric  <= s_axis_tdata[111:96];
            key_iface_reg   <= in_iface_ext[IFACE_BITS-1:0];
            unique case (in_cmd)
                CMD_ADD:   key_reg.dest <= s_axis_tdata[31:0] & s_axis_tdata[63:32];
                CMD_DEFRT: key_reg.dest <= s_axis_tdata[95:64];
                default:   key_reg.dest <= s_axis_tdata[31:0];
            endcase
        end
        else if ((state_reg == ST_APPLY) && (op_reg == CMD_DEFRT) && defrt_ok)
        begin
            // second pass adds 0/0 through the interface of the direct route
            key_reg.dest  <= '0;
            key_reg.mask  <= '0;
            key_iface_reg <= found_iface;
        end

        if (state_reg == ST_APPLY)
        begin
            // hit fields only carry data on a lookup
            res_key_reg   <= (op_reg == CMD_LOOKUP) ? found_key : '0;
            res_iface_reg <= (op_reg == CMD_LOOKUP) ? out_iface_ext[IFACE_W-1:0] : '0;
            case (op_reg)
                CMD_ADD:
                begin
                    res_status_reg <= dup_reg ? STS_EXISTS : (full_reg ? STS_FULL : STS_OK);
                end
                CMD_DEL:
                begin
                    res_status_reg <= any_reg ? STS_OK : STS_NOTFOUND;
                end
                CMD_LOOKUP:
                begin
                    res_status_reg <= any_reg ? STS_OK : STS_NOTFOUND;
                end
                default:
                begin
                    res_status_reg <= STS_NOTFOUND;
                end
            endcase
        end

        if ((state_reg == ST_RESP) && out_free)
        begin
            m_tdata_reg <= {4'b0, res_iface_reg, res_key_reg.metric, res_key_reg.gateway,
                            res_key_reg.mask, res_key_reg.dest};
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // ------------------------------------------------------------ checks
    `ORTL_ASSERT(a_valid_prefix, (valid_v & (valid_v + VEC_ONE)) == '0,
        "valid routes do not form a prefix of the table")
    `ORTL_ASSERT(a_lookup_onehot,
        !((state_reg == ST_APPLY) && ((op_reg == CMD_LOOKUP) || (op_reg == CMD_DEFRT)))
        || $onehot0(sel_reg), "lookup selected more than one route")
    `ORTL_ASSERT_NEXT(a_add_grows, (state_reg == ST_APPLY) && (op_reg == CMD_ADD) && add_ok,
        $countones(valid_v) == $countones($past(valid_v)) + 1, "add did not grow the table")
    `ORTL_ASSERT_NEXT(a_del_shrinks, (state_reg == ST_APPLY) && (op_reg == CMD_DEL) && any_reg,
        $countones(valid_v) + 1 == $countones($past(valid_v)), "delete did not shrink the table")

endmodule

// ===== sv/ortl_cell.sv =====
// ----------------------------------------------------------------------------
// Route table cell
// Holds one route, compares it against the broadcast key and shifts with
// its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module ortl_cell
    import ortl_pkg::*;
#(
    parameter int IFACE_BITS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_op_t              op,
    input  route_key_t            key,
    input  logic [IFACE_BITS-1:0] key_iface,
    input  logic                  prev_valid,
    input  route_key_t            prev_entry,
    input  logic [IFACE_BITS-1:0] prev_iface,
    input  logic                  next_valid,
    input  route_key_t            next_entry,
    input  logic [IFACE_BITS-1:0] next_iface,
    output logic                  valid,
    output route_key_t            entry,
    output logic [IFACE_BITS-1:0] iface,
    output cell_flags_t           flags
);

    logic                  valid_reg;
    route_key_t            entry_reg;
    logic [IFACE_BITS-1:0] iface_reg;
    cell_flags_t           flags_reg;
    cell_flags_t           flags_next;

    always_comb
    begin
        flags_next.hit = valid_reg && ((key.dest & entry_reg.mask) == entry_reg.dest);
        flags_next.eq  = valid_reg && (entry_reg.dest == key.dest)
                         && (entry_reg.mask == key.mask)
                         && (entry_reg.metric == key.metric);
        // new route goes at or before this slot
        flags_next.ins = !valid_reg || (entry_reg.mask < key.mask)
                         || ((entry_reg.mask == key.mask) && (entry_reg.metric < key.metric));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            case (op)
                CELL_LOAD: valid_reg <= 1'b1;
                CELL_PREV: valid_reg <= prev_valid;
                CELL_NEXT: valid_reg <= next_valid;
                default:   valid_reg <= valid_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            CELL_LOAD:
            begin
                entry_reg <= key;
                iface_reg <= key_iface;
            end
            CELL_PREV:
            begin
                entry_reg <= prev_entry;
                iface_reg <= prev_iface;
            end
            CELL_NEXT:
            begin
                entry_reg <= next_entry;
                iface_reg <= next_iface;
            end
            default:
            begin
                entry_reg <= entry_reg;
                iface_reg <= iface_reg;
            end
        endcase
    end

    assign valid = valid_reg;
    assign entry = entry_reg;
    assign iface = iface_reg;
    assign flags = flags_reg;

endmodule
